### hw/rtl/srwt_pkg.sv
`timescale 1ns / 1ps

package srwt_pkg;

    localparam int unsigned WINDOW_BITS_DEF = 64;
    localparam logic [31:0] VALID_RANGE_RST = 32'h0001_0000;
    localparam logic [31:0] CTR_MAX         = 32'hFFFF_FFFF;

    typedef enum logic {
        ACT_INSERT   = 1'b0,
        ACT_FINALIZE = 1'b1
    } action_t;

    typedef struct packed {
        action_t     action;
        logic [63:0] seq_number;
    } in_t;

    typedef struct packed {
        logic [31:0] total_received;
        logic [31:0] missed_total;
        logic [31:0] invalid_total;
        logic [31:0] duplicate_total;
        logic [31:0] disorder_total;
        logic [63:0] first_seen;
        logic [63:0] highest_seen;
        logic [63:0] window_base;
    } out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_RUN,
        S_FAR,
        S_FAR_END,
        S_FIN,
        S_FIN_END,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic classify;
        logic fin_start;
        logic run_step;
        logic far_step;
        logic far_end;
        logic fin_step;
        logic fin_end;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_final;
        logic run;
        logic far;
        logic cnt_done;
        logic bit0;
    } sts_t;

    // saturating add of a wide amount to a 32-bit counter
    function automatic logic [31:0] sat_add(input logic [31:0] ctr, input logic [63:0] amt);
        logic [63:0] room;
        room = {32'd0, ~ctr};
        if (amt > room) begin
            sat_add = CTR_MAX;
        end else begin
            sat_add = ctr + amt[31:0];
        end
    endfunction

endpackage

### hw/rtl/srwt_ctrl.sv
`timescale 1ns / 1ps

module srwt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  srwt_pkg::sts_t  sts,
    output srwt_pkg::cmd_t  cmd
);
    import srwt_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                if (sts.is_final)
                begin
                    cmd.fin_start = 1'b1;
                    state_next    = S_FIN;
                end
                else
                begin
                    cmd.classify = 1'b1;
                    if (sts.far)
                        state_next = S_FAR;
                    else if (sts.run)
                        state_next = S_RUN;
                    else
                        state_next = S_DONE;
                end
            end
            S_RUN:
            begin
                if (sts.bit0)
                    cmd.run_step = 1'b1;
                else
                    state_next = S_DONE;
            end
            S_FAR:
            begin
                if (sts.cnt_done)
                    state_next = S_FAR_END;
                else
                    cmd.far_step = 1'b1;
            end
            S_FAR_END:
            begin
                cmd.far_end = 1'b1;
                state_next  = S_DONE;
            end
            S_FIN:
            begin
                if (sts.cnt_done)
                    state_next = S_FIN_END;
                else
                    cmd.fin_step = 1'b1;
            end
            S_FIN_END:
            begin
                cmd.fin_end = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

### hw/rtl/srwt_dp.sv
`timescale 1ns / 1ps

module srwt_dp #(
    parameter int unsigned WINDOW_BITS = srwt_pkg::WINDOW_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  srwt_pkg::in_t   in_data,
    input  logic            cfg_we,
    input  logic [31:0]     cfg_wdata,
    input  srwt_pkg::cmd_t  cmd,
    output srwt_pkg::sts_t  sts,
    output srwt_pkg::out_t  out_data
);
    import srwt_pkg::*;

    localparam int unsigned IDXW = $clog2(WINDOW_BITS);
    localparam int unsigned CW   = $clog2(WINDOW_BITS + 1);

    action_t                act_reg;
    logic [63:0]            seq_reg;
    logic [63:0]            n_reg, n_next;
    out_t                   out_reg;

    logic [31:0]            vrange_reg, vrange_next;
    logic [WINDOW_BITS-1:0] bmap_reg, bmap_next;
    logic [63:0]            base_reg, base_next;
    logic                   anch_reg, anch_next;
    logic [63:0]            prev_reg, prev_next;
    logic [63:0]            anchor_reg, anchor_next;
    logic [63:0]            max_reg, max_next;
    logic [31:0]            tot_reg, tot_next;
    logic [31:0]            mis_reg, mis_next;
    logic [31:0]            inv_reg, inv_next;
    logic [31:0]            dup_reg, dup_next;
    logic [31:0]            dis_reg, dis_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [CW-1:0]          lim_reg, lim_next;
    logic [CW-1:0]          ones_reg, ones_next;
    logic [CW-1:0]          zero_reg, zero_next;
    logic [CW-1:0]          gap_reg, gap_next;

    logic [63:0]            delta;
    logic [63:0]            dist_eff;
    logic [63:0]            n_calc;
    logic                   invalid;
    logic                   near;
    logic [IDXW-1:0]        idx;

    assign delta    = seq_reg - base_reg;
    assign invalid  = anch_reg && (delta >= {32'd0, vrange_reg});
    assign dist_eff = anch_reg ? delta : 64'd0;
    assign near     = dist_eff < 64'(WINDOW_BITS);
    assign idx      = dist_eff[IDXW-1:0];
    assign n_calc   = dist_eff - 64'(WINDOW_BITS - 1);

    assign sts.is_final = (act_reg == ACT_FINALIZE);
    assign sts.run      = !invalid && (dist_eff == 64'd0);
    assign sts.far      = !invalid && !near;
    assign sts.cnt_done = (cnt_reg == lim_reg);
    assign sts.bit0     = bmap_reg[0];

    always_comb
    begin
        vrange_next = cfg_we ? cfg_wdata : vrange_reg;
        bmap_next   = bmap_reg;
        base_next   = base_reg;
        anch_next   = anch_reg;
        prev_next   = prev_reg;
        anchor_next = anchor_reg;
        max_next    = max_reg;
        tot_next    = tot_reg;
        mis_next    = mis_reg;
        inv_next    = inv_reg;
        dup_next    = dup_reg;
        dis_next    = dis_reg;
        cnt_next    = cnt_reg;
        lim_next    = lim_reg;
        ones_next   = ones_reg;
        zero_next   = zero_reg;
        gap_next    = gap_reg;
        n_next      = n_reg;

        if (cmd.classify)
        begin
            tot_next  = sat_add(tot_reg, 64'd1);
            prev_next = seq_reg;
            if (!anch_reg)
            begin
                base_next   = seq_reg;
                anchor_next = seq_reg;
                anch_next   = 1'b1;
            end
            else if (invalid)
                inv_next = sat_add(inv_reg, 64'd1);
            else if (seq_reg != prev_reg + 64'd1)
                dis_next = sat_add(dis_reg, 64'd1);

            if (!invalid)
            begin
                if (seq_reg > max_reg)
                    max_next = seq_reg;
                if (near)
                begin
                    if (bmap_reg[idx])
                        dup_next = sat_add(dup_reg, 64'd1);
                    bmap_next[idx] = 1'b1;
                end
            end
            n_next    = n_calc;
            cnt_next  = '0;
            ones_next = '0;
            lim_next  = (n_calc >= 64'(WINDOW_BITS)) ? CW'(WINDOW_BITS) : n_calc[CW-1:0];
        end

        if (cmd.run_step)
        begin
            bmap_next = bmap_reg >> 1;
            base_next = base_reg + 64'd1;
        end

        if (cmd.far_step)
        begin
            ones_next = ones_reg + CW'(bmap_reg[0]);
            bmap_next = bmap_reg >> 1;
            cnt_next  = cnt_reg + CW'(1);
        end

        if (cmd.far_end)
        begin
            mis_next = sat_add(mis_reg, n_reg - 64'(ones_reg));
            base_next = base_reg + n_reg;
            bmap_next[WINDOW_BITS-1] = 1'b1;
        end

        if (cmd.fin_start)
        begin
            cnt_next  = '0;
            lim_next  = CW'(WINDOW_BITS);
            zero_next = '0;
            gap_next  = '0;
        end

        if (cmd.fin_step)
        begin
            // gap holds the zeros seen below the latest set bit
            if (bmap_reg[0])
                gap_next = zero_reg;
            else
                zero_next = zero_reg + CW'(1);
            bmap_next = {bmap_reg[0], bmap_reg[WINDOW_BITS-1:1]};
            cnt_next  = cnt_reg + CW'(1);
        end

        if (cmd.fin_end)
            mis_next = sat_add(mis_reg, 64'(gap_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vrange_reg <= VALID_RANGE_RST;
            bmap_reg   <= '0;
            base_reg   <= '0;
            anch_reg   <= 1'b0;
            prev_reg   <= '0;
            anchor_reg <= '0;
            max_reg    <= '0;
            tot_reg    <= '0;
            mis_reg    <= '0;
            inv_reg    <= '0;
            dup_reg    <= '0;
            dis_reg    <= '0;
            cnt_reg    <= '0;
            lim_reg    <= '0;
            ones_reg   <= '0;
            zero_reg   <= '0;
            gap_reg    <= '0;
        end
        else
        begin
            vrange_reg <= vrange_next;
            bmap_reg   <= bmap_next;
            base_reg   <= base_next;
            anch_reg   <= anch_next;
            prev_reg   <= prev_next;
            anchor_reg <= anchor_next;
            max_reg    <= max_next;
            tot_reg    <= tot_next;
            mis_reg    <= mis_next;
            inv_reg    <= inv_next;
            dup_reg    <= dup_next;
            dis_reg    <= dis_next;
            cnt_reg    <= cnt_next;
            lim_reg    <= lim_next;
            ones_reg   <= ones_next;
            zero_reg   <= zero_next;
            gap_reg    <= gap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        if (cmd.load)
        begin
            act_reg <= in_data.action;
            seq_reg <= in_data.seq_number;
        end
        if (cmd.out_load)
        begin
            out_reg.total_received  <= tot_reg;
            out_reg.missed_total    <= mis_reg;
            out_reg.invalid_total   <= inv_reg;
            out_reg.duplicate_total <= dup_reg;
            out_reg.disorder_total  <= dis_reg;
            out_reg.first_seen      <= anchor_reg;
            out_reg.highest_seen    <= max_reg;
            out_reg.window_base     <= base_reg;
        end
    end

    assign out_data = out_reg;

endmodule

### hw/rtl/sequence_receive_window_tracker_unit.sv
`timescale 1ns / 1ps
// Sequence: accept, classify, result; an insert that neither slides nor jumps goes straight on;
//   a slide at the base first walks the run of set bits (the anchoring insert always slides),
//   a jump past the top first scans min(n, WINDOW_BITS) bits, finalize scans WINDOW_BITS bits.
// Throughput: one word in flight; the next word is taken as the result appears; the bitmap
//   scan walks one bit per cycle.
// Reset (rst_n, async, active low): empty map, counters zero, valid_range 65536.

module sequence_receive_window_tracker_unit #(
    parameter int unsigned WINDOW_BITS = srwt_pkg::WINDOW_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  srwt_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output srwt_pkg::out_t out_data,
    input  logic           cfg_we,
    input  logic [31:0]    cfg_wdata
);
    import srwt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Controller: sequence classify, the one-bit-per-cycle scan and the result hand-off.
    srwt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: window map, base, counters and the output word register.
    srwt_dp #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (out_data)
    );

endmodule

### hw/rtl/srwt_checker.sv
`timescale 1ns / 1ps

module srwt_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input srwt_pkg::out_t out_data
);
    import srwt_pkg::*;

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // busy once a word is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted while busy");

    // total never drops from one result word to the next
    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=>
            !out_valid || out_data.total_received >= $past(out_data.total_received))
        else $error("total went down");

    // invalid, duplicate and disorder each count at most once per insert
    a_ctr_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.total_received >= out_data.invalid_total &&
                      out_data.total_received >= out_data.duplicate_total &&
                      out_data.total_received >= out_data.disorder_total)
        else $error("counter above total");

endmodule

bind sequence_receive_window_tracker_unit srwt_checker u_srwt_checker (.*);
